FILE: rtl/dfc_pkg.sv
// Package with shared types, mode codes and derived widths of the face coupling block.
`default_nettype none
package dfc_pkg;
    localparam int unsigned VW = 32;
    localparam int unsigned FB = 16;
    localparam int unsigned NUM_W = 2 * VW + FB + 1;
    localparam int unsigned DEN_W = 2 * VW + 1;

    localparam logic [1:0] MODE_REFLECT  = 2'd0;
    localparam logic [1:0] MODE_ZERO_FLUX = 2'd1;
    localparam logic [1:0] MODE_VACUUM   = 2'd2;
    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;
    localparam int unsigned REG_COUNT = 6;

    typedef struct packed {
        logic [1:0]    axis;
        logic          face_active;
        logic          at_low_boundary;
        logic          at_high_boundary;
        logic [VW-1:0] coef_before;
        logic [VW-1:0] width_before;
        logic [VW-1:0] coef_after;
        logic [VW-1:0] width_after;
    } face_in_t;

    typedef struct packed {
        logic [VW-1:0] coupling;
        logic          saturated;
    } face_out_t;

    typedef enum logic [1:0] {
        KIND_ZERO,
        KIND_BOUNDARY,
        KIND_VACUUM,
        KIND_INTERIOR
    } kind_t;

    typedef struct packed {
        kind_t         kind;
        logic [VW-1:0] d_a;
        logic [VW-1:0] h_a;
        logic [VW-1:0] d_b;
        logic [VW-1:0] h_b;
    } job_t;

    typedef struct packed {
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
        logic             zero;
    } div_req_t;
endpackage
`default_nettype wire

FILE: rtl/diffusion_face_coupling.sv
// Top level of the diffusion face coupling block with its mode registers.
//
// Channel | Direction | Handshake        | Payload
// in      | input     | in_valid/stall   | face_in_t
// out     | output    | out_valid/stall  | face_out_t
// cfg     | input     | cfg_valid/ready  | index, data
//
// One face enters per cycle while the input is not stalled; each result passes
// through the one-bit-per-stage divider pipeline of 81 stages.
// Reset clears the mode registers and all valid flags.
// A stall on the output freezes the back end; the queue and the front register
// then hold up to three faces before the input stalls.
`default_nettype none
module diffusion_face_coupling (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire dfc_pkg::face_in_t  in_data,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output dfc_pkg::face_out_t      out_data,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [1:0]         cfg_data
);
    import dfc_pkg::*;

    logic [11:0] modes_reg;
    logic        fq_valid;
    logic        fq_stall;
    job_t        fq_job;
    logic        qb_valid;
    logic        qb_stall;
    job_t        qb_job;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modes_reg <= '0;
        end
        else if (cfg_valid && cfg_index < 3'(REG_COUNT))
        begin
            modes_reg[{cfg_index, 1'b0} +: 2] <= cfg_data;
        end
    end

    dfc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .modes     (modes_reg),
        .job_valid (fq_valid),
        .job_stall (fq_stall),
        .job       (fq_job)
    );

    dfc_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (fq_valid),
        .wr_stall (fq_stall),
        .wr_data  (fq_job),
        .rd_valid (qb_valid),
        .rd_stall (qb_stall),
        .rd_data  (qb_job)
    );

    dfc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (qb_valid),
        .job_stall (qb_stall),
        .job       (qb_job),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );
endmodule
`default_nettype wire

FILE: rtl/dfc_front.sv
// Front stage: drops inactive faces, picks the boundary rule and registers a job.
`default_nettype none
module dfc_front (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire dfc_pkg::face_in_t  in_data,
    input  wire logic [11:0]        modes,
    output logic                    job_valid,
    input  wire logic               job_stall,
    output dfc_pkg::job_t           job
);
    import dfc_pkg::*;

    logic  job_valid_reg;
    job_t  job_reg;
    job_t  job_next;
    logic  [1:0] mode;
    logic  take;

    assign in_stall  = job_valid_reg && job_stall;
    assign take      = in_valid && !in_stall;
    assign job_valid = job_valid_reg;
    assign job       = job_reg;

    always_comb
    begin
        mode = MODE_REFLECT;
        case (in_data.axis)
            AXIS_X:  mode = in_data.at_low_boundary ? modes[1:0] : modes[3:2];
            AXIS_Y:  mode = in_data.at_low_boundary ? modes[5:4] : modes[7:6];
            AXIS_Z:  mode = in_data.at_low_boundary ? modes[9:8] : modes[11:10];
            default: mode = MODE_REFLECT;
        endcase
        job_next.d_a = in_data.at_low_boundary ? in_data.coef_after : in_data.coef_before;
        job_next.h_a = in_data.at_low_boundary ? in_data.width_after : in_data.width_before;
        job_next.d_b = in_data.coef_after;
        job_next.h_b = in_data.width_after;
        if (in_data.at_low_boundary || in_data.at_high_boundary)
        begin
            case (mode)
                MODE_ZERO_FLUX: job_next.kind = KIND_BOUNDARY;
                MODE_VACUUM:    job_next.kind = KIND_VACUUM;
                default:        job_next.kind = KIND_ZERO;
            endcase
        end
        else
        begin
            job_next.kind = KIND_INTERIOR;
            job_next.d_a  = in_data.coef_before;
            job_next.h_a  = in_data.width_before;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            job_valid_reg <= take && in_data.face_active;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            job_reg <= job_next;
        end
    end
endmodule
`default_nettype wire

FILE: rtl/dfc_queue.sv
// Two-entry queue between the front stage and the arithmetic back end.
`default_nettype none
module dfc_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          wr_valid,
    output logic               wr_stall,
    input  wire dfc_pkg::job_t wr_data,
    output logic               rd_valid,
    input  wire logic          rd_stall,
    output dfc_pkg::job_t      rd_data
);
    import dfc_pkg::*;

    job_t       mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push;
    logic       pop;

    assign wr_stall = (count_reg == 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign rd_data  = mem_reg[rd_ptr_reg];
    assign push     = wr_valid && !wr_stall;
    assign pop      = rd_valid && !rd_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end
endmodule
`default_nettype wire

FILE: rtl/dfc_back.sv
// Back end: products, a pipelined restoring divider and the saturating output register.
`default_nettype none
module dfc_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          job_valid,
    output logic               job_stall,
    input  wire dfc_pkg::job_t job,
    output logic               out_valid,
    input  wire logic          out_stall,
    output dfc_pkg::face_out_t out_data
);
    import dfc_pkg::*;

    localparam int unsigned STAGES = NUM_W;
    localparam int unsigned QW = NUM_W;

    logic adv;

    // Product stage.
    logic             p_valid_reg;
    kind_t            p_kind_reg;
    logic [2*VW-1:0]  p_dd_reg;
    logic [2*VW-1:0]  p_ab_reg;
    logic [2*VW-1:0]  p_ba_reg;
    logic [VW-1:0]    p_d_reg;
    logic [VW-1:0]    p_h_reg;

    // Request stage.
    logic             r_valid_reg;
    div_req_t         r_req_reg;
    div_req_t         r_req_next;

    // Divider pipeline.
    logic             s_valid_reg [STAGES+1];
    logic [DEN_W:0]   s_rem_reg   [STAGES+1];
    logic [NUM_W-1:0] s_num_reg   [STAGES+1];
    logic [DEN_W-1:0] s_den_reg   [STAGES+1];
    logic [QW-1:0]    s_quo_reg   [STAGES+1];
    logic             s_zero_reg  [STAGES+1];

    logic             out_valid_reg;
    face_out_t        out_reg;
    face_out_t        out_next;
    logic [QW-1:0]    q_last;

    assign adv       = !(out_valid_reg && out_stall);
    assign job_stall = !adv;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_comb
    begin
        r_req_next.zero = 1'b0;
        r_req_next.num  = '0;
        r_req_next.den  = '0;
        case (p_kind_reg)
            KIND_BOUNDARY:
            begin
                r_req_next.num = NUM_W'({p_d_reg, {(FB+1){1'b0}}});
                r_req_next.den = DEN_W'(p_h_reg);
            end
            KIND_VACUUM:
            begin
                r_req_next.num = NUM_W'({p_d_reg, {(FB+1){1'b0}}});
                r_req_next.den = DEN_W'(p_h_reg) + DEN_W'({p_d_reg, 2'b00});
            end
            KIND_INTERIOR:
            begin
                r_req_next.num = NUM_W'({p_dd_reg, {(FB+1){1'b0}}});
                r_req_next.den = DEN_W'(p_ab_reg) + DEN_W'(p_ba_reg);
            end
            default:
            begin
                r_req_next.zero = 1'b1;
                r_req_next.den  = DEN_W'(1);
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg   <= 1'b0;
            r_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i <= STAGES; i++)
            begin
                s_valid_reg[i] <= 1'b0;
            end
        end
        else if (adv)
        begin
            p_valid_reg    <= job_valid;
            r_valid_reg    <= p_valid_reg;
            s_valid_reg[0] <= r_valid_reg;
            for (int i = 1; i <= STAGES; i++)
            begin
                s_valid_reg[i] <= s_valid_reg[i-1];
            end
            out_valid_reg  <= s_valid_reg[STAGES];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p_kind_reg <= job.kind;
            p_dd_reg   <= job.d_a * job.d_b;
            p_ab_reg   <= job.d_a * job.h_b;
            p_ba_reg   <= job.d_b * job.h_a;
            p_d_reg    <= job.d_a;
            p_h_reg    <= job.h_a;
            r_req_reg  <= r_req_next;
            s_rem_reg[0]  <= '0;
            s_num_reg[0]  <= r_req_reg.num;
            s_den_reg[0]  <= r_req_reg.den;
            s_quo_reg[0]  <= '0;
            s_zero_reg[0] <= r_req_reg.zero;
            for (int i = 1; i <= STAGES; i++)
            begin
                logic [DEN_W:0] trial;
                trial = {s_rem_reg[i-1][DEN_W-1:0], s_num_reg[i-1][NUM_W-i]};
                if (trial >= {1'b0, s_den_reg[i-1]})
                begin
                    s_rem_reg[i] <= trial - {1'b0, s_den_reg[i-1]};
                    s_quo_reg[i] <= {s_quo_reg[i-1][QW-2:0], 1'b1};
                end
                else
                begin
                    s_rem_reg[i] <= trial;
                    s_quo_reg[i] <= {s_quo_reg[i-1][QW-2:0], 1'b0};
                end
                s_num_reg[i]  <= s_num_reg[i-1];
                s_den_reg[i]  <= s_den_reg[i-1];
                s_zero_reg[i] <= s_zero_reg[i-1];
            end
            out_reg <= out_next;
        end
    end

    always_comb
    begin
        q_last = s_quo_reg[STAGES];
        if (s_zero_reg[STAGES])
        begin
            out_next.coupling  = '0;
            out_next.saturated = 1'b0;
        end
        else if (s_den_reg[STAGES] == '0 || q_last[QW-1:VW] != '0)
        begin
            out_next.coupling  = '1;
            out_next.saturated = 1'b1;
        end
        else
        begin
            out_next.coupling  = q_last[VW-1:0];
            out_next.saturated = 1'b0;
        end
    end
endmodule
`default_nettype wire

FILE: rtl/dfc_checker.sv
// Port-level checker for the face coupling block and its bind statement.
`default_nettype none
module dfc_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_stall,
    input wire logic               out_valid,
    input wire logic               out_stall,
    input wire dfc_pkg::face_out_t out_data,
    input wire logic               cfg_ready
);
    import dfc_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("Stalled result changed.");

    a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.saturated |-> out_data.coupling == '1)
        else $error("Saturated result is not all ones.");

    a_in_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid ##1 !out_valid |-> !in_stall)
        else $error("Input stalled with an empty output.");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("Configuration port not ready.");
endmodule

bind diffusion_face_coupling dfc_checker u_dfc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_ready (cfg_ready)
);
`default_nettype wire

FILE: sim/testbench.sv
// Self-checking testbench for the diffusion face coupling block.
`default_nettype none
module testbench;
    import dfc_pkg::*;

    localparam int unsigned LATENCY = 120;
    localparam logic [2:0] REG_X_LOW  = 3'd0;
    localparam logic [2:0] REG_X_HIGH = 3'd1;
    localparam logic [2:0] REG_Y_LOW  = 3'd2;
    localparam logic [2:0] REG_Y_HIGH = 3'd3;
    localparam logic [2:0] REG_Z_LOW  = 3'd4;
    localparam logic [2:0] REG_Z_HIGH = 3'd5;
    localparam logic [1:0] AXIS_NONE  = 2'd3;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    face_in_t in_data;
    logic out_valid;
    logic out_stall;
    face_out_t out_data;
    logic cfg_valid;
    logic cfg_ready;
    logic [2:0] cfg_index;
    logic [1:0] cfg_data;

    logic [1:0] mode_regs [REG_COUNT];
    face_out_t coupling_queue [$];
    int errors;
    int stall_mode;

    diffusion_face_coupling dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #20000000;
        $display("status: fail");
        $finish;
    end

    function automatic face_out_t divide_q(logic [191:0] num, logic [191:0] den);
        face_out_t r;
        logic [191:0] q;
        if (den == 0)
        begin
            r.coupling = '1;
            r.saturated = 1'b1;
            return r;
        end
        q = num / den;
        if (q[191:VW] != 0)
        begin
            r.coupling = '1;
            r.saturated = 1'b1;
        end
        else
        begin
            r.coupling = q[VW-1:0];
            r.saturated = 1'b0;
        end
        return r;
    endfunction

    function automatic face_out_t face_coupling(face_in_t f);
        face_out_t r;
        logic [1:0] mode;
        logic [191:0] d;
        logic [191:0] h;
        logic [191:0] dl, hl, dr, hr;
        dl = 192'(f.coef_before);
        hl = 192'(f.width_before);
        dr = 192'(f.coef_after);
        hr = 192'(f.width_after);
        r = '0;
        if (f.at_low_boundary || f.at_high_boundary)
        begin
            mode = MODE_REFLECT;
            d = f.at_low_boundary ? dr : dl;
            h = f.at_low_boundary ? hr : hl;
            if (f.axis != AXIS_NONE)
                mode = mode_regs[{f.axis, !f.at_low_boundary}];
            if (mode == MODE_ZERO_FLUX)
                r = divide_q(d << (FB + 1), h);
            else if (mode == MODE_VACUUM)
                r = divide_q(d << (FB + 1), h + (d << 2));
        end
        else
            r = divide_q((dl * dr) << (FB + 1), dl * hr + dr * hl);
        return r;
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            case (stall_mode)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 3) == 0);
                default: out_stall <= ($urandom_range(0, 9) < 7);
            endcase
            if ($urandom_range(0, 199) == 0)
                stall_mode <= $urandom_range(0, 2);
        end
    end

    always @(posedge clk)
    begin
        face_out_t exp_r;
        if (rst_n && out_valid && !out_stall)
        begin
            if (coupling_queue.size() == 0)
            begin
                $error("unexpected result coupling=%h", out_data.coupling);
                errors++;
            end
            else
            begin
                exp_r = coupling_queue.pop_front();
                if (out_data.coupling !== exp_r.coupling)
                begin
                    $error("coupling expected %h actual %h", exp_r.coupling, out_data.coupling);
                    errors++;
                end
                if (out_data.saturated !== exp_r.saturated)
                begin
                    $error("saturated expected %b actual %b", exp_r.saturated,
                           out_data.saturated);
                    errors++;
                end
            end
        end
    end

    task automatic send_face(face_in_t f);
        in_valid <= 1'b1;
        in_data <= f;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (f.face_active)
            coupling_queue.push_back(face_coupling(f));
        if ($urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    task automatic finish_face;
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        while (coupling_queue.size() != 0)
            @(posedge clk);
        repeat (LATENCY) @(posedge clk);
    endtask

    task automatic write_mode(logic [2:0] idx, logic [1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        mode_regs[idx] = val;
    endtask

    task automatic write_all_modes(logic [1:0] m0, logic [1:0] m1, logic [1:0] m2,
                                   logic [1:0] m3, logic [1:0] m4, logic [1:0] m5);
        write_mode(REG_X_LOW, m0);
        write_mode(REG_X_HIGH, m1);
        write_mode(REG_Y_LOW, m2);
        write_mode(REG_Y_HIGH, m3);
        write_mode(REG_Z_LOW, m4);
        write_mode(REG_Z_HIGH, m5);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic face_in_t make_face(logic [1:0] axis, logic act, logic lo, logic hi,
                                           logic [31:0] dl, logic [31:0] hl,
                                           logic [31:0] dr, logic [31:0] hr);
        face_in_t f;
        f.axis = axis;
        f.face_active = act;
        f.at_low_boundary = lo;
        f.at_high_boundary = hi;
        f.coef_before = dl;
        f.width_before = hl;
        f.coef_after = dr;
        f.width_after = hr;
        return f;
    endfunction

    function automatic logic [31:0] rand_value();
        case ($urandom_range(0, 7))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom_range(1, 8);
            3: return $urandom;
            default: return $urandom_range(32'h0000_4000, 32'h0008_0000);
        endcase
    endfunction

    task automatic test_interior_faces;
        send_face(make_face(AXIS_X, 1, 0, 0, 32'h0001_0000, 32'h0001_0000,
                            32'h0001_0000, 32'h0001_0000));
        send_face(make_face(AXIS_Y, 1, 0, 0, 32'h0, 32'h0, 32'h0, 32'h0));
        send_face(make_face(AXIS_Z, 1, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                            32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_face(make_face(AXIS_NONE, 1, 0, 0, 32'hFFFF_FFFF, 32'h1,
                            32'hFFFF_FFFF, 32'h1));
        send_face(make_face(AXIS_X, 1, 0, 0, 32'h0, 32'h0001_0000,
                            32'h0002_0000, 32'h0001_0000));
        send_face(make_face(AXIS_X, 0, 0, 0, 32'h1234, 32'h5678, 32'h9ABC, 32'hDEF0));
        finish_face();
        drain();
    endtask

    task automatic test_boundary_faces;
        write_all_modes(MODE_ZERO_FLUX, MODE_VACUUM, MODE_VACUUM, MODE_ZERO_FLUX,
                        MODE_REFLECT, MODE_UNUSED);
        send_face(make_face(AXIS_X, 1, 1, 0, 32'h5, 32'h5, 32'h0001_0000, 32'h0000_8000));
        send_face(make_face(AXIS_X, 1, 0, 1, 32'h0001_0000, 32'h0002_0000, 32'h5, 32'h5));
        send_face(make_face(AXIS_Y, 1, 1, 1, 32'h1, 32'h1, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_face(make_face(AXIS_Y, 1, 0, 1, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0));
        send_face(make_face(AXIS_Z, 1, 1, 0, 32'h0, 32'h0, 32'hFFFF_FFFF, 32'h1));
        send_face(make_face(AXIS_Z, 1, 0, 1, 32'hFFFF_FFFF, 32'h1, 32'h0, 32'h0));
        send_face(make_face(AXIS_NONE, 1, 1, 0, 32'h1, 32'h1, 32'hFFFF, 32'h1));
        send_face(make_face(AXIS_X, 1, 1, 0, 32'h0, 32'h0, 32'h0, 32'h0));
        send_face(make_face(AXIS_Y, 0, 1, 1, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0));
        finish_face();
        drain();
        write_all_modes(MODE_VACUUM, MODE_ZERO_FLUX, MODE_ZERO_FLUX, MODE_VACUUM,
                        MODE_VACUUM, MODE_ZERO_FLUX);
        send_face(make_face(AXIS_X, 1, 1, 0, 32'h0, 32'h0, 32'h0, 32'h0));
        send_face(make_face(AXIS_X, 1, 0, 1, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0));
        send_face(make_face(AXIS_Z, 1, 1, 0, 32'h0, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_face(make_face(AXIS_Z, 1, 0, 1, 32'h0001_0000, 32'h0, 32'h0, 32'h0));
        finish_face();
        drain();
    endtask

    task automatic test_random_faces(int count);
        int sent;
        sent = 0;
        while (sent < count)
        begin
            face_in_t f;
            f.axis = 2'($urandom_range(0, 3));
            f.face_active = ($urandom_range(0, 7) != 0);
            f.at_low_boundary = ($urandom_range(0, 2) == 0);
            f.at_high_boundary = ($urandom_range(0, 2) == 0);
            f.coef_before = rand_value();
            f.width_before = rand_value();
            f.coef_after = rand_value();
            f.width_after = rand_value();
            send_face(f);
            if (f.face_active)
                sent++;
            if ($urandom_range(0, 15) == 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(5, 40)) @(posedge clk);
            end
        end
        finish_face();
        drain();
    endtask

    task automatic test_random_settings;
        int phase;
        for (phase = 0; phase < 4; phase++)
        begin
            write_all_modes(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                            2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                            2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)));
            test_random_faces(90);
        end
    endtask

    initial
    begin
        errors = 0;
        stall_mode = 1;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        for (int i = 0; i < REG_COUNT; i++)
            mode_regs[i] = MODE_REFLECT;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_interior_faces();
        test_boundary_faces();
        test_random_settings();
        write_all_modes(MODE_REFLECT, MODE_REFLECT, MODE_REFLECT, MODE_REFLECT,
                        MODE_REFLECT, MODE_REFLECT);
        test_random_faces(30);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
`default_nettype wire
